// ===== src/lpfd_pkg.sv =====
`timescale 1ns / 1ps

package lpfd_pkg;

   // frame layout
   localparam logic [31:0] MinFrameLen  = 32'd5;
   localparam int          FieldBytes   = 4;
   localparam logic [1:0]  LastFieldIdx = 2'(FieldBytes - 1);

   // parser phases
   localparam logic [1:0] PhLength  = 2'd0;
   localparam logic [1:0] PhType    = 2'd1;
   localparam logic [1:0] PhStream  = 2'd2;
   localparam logic [1:0] PhPayload = 2'd3;

   // result status codes
   localparam logic [1:0] StPayload = 2'd0;
   localparam logic [1:0] StEmpty   = 2'd1;
   localparam logic [1:0] StLenErr  = 2'd2;
   localparam logic [1:0] StTypeErr = 2'd3;

   // frame kinds
   localparam logic KindControl = 1'b0;
   localparam logic KindBinary  = 1'b1;

   // register indexes
   localparam logic [1:0] CsrMaxFrameLength = 2'd0;
   localparam logic [1:0] CsrControlType    = 2'd1;
   localparam logic [1:0] CsrBinaryType     = 2'd2;

   // register reset values
   localparam logic [31:0] MaxFrameLengthReset = 32'd16777221;
   localparam logic [7:0]  ControlTypeReset    = 8'd1;
   localparam logic [7:0]  BinaryTypeReset     = 8'd2;

   typedef struct packed {
      logic [31:0] max_frame_length;
      logic [7:0]  control_type_code;
      logic [7:0]  binary_type_code;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  phase;
      logic [1:0]  idx;
      logic [31:0] len_acc;
      logic [31:0] remaining;
      logic [31:0] stream;
      logic        kind;
      logic        failed;
   } state_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        frame_kind;
      logic [31:0] stream_number;
      logic [7:0]  payload_byte;
      logic        last_of_frame;
   } result_type;

endpackage

// ===== src/lpfd_step.sv =====
`timescale 1ns / 1ps

// Per-beat parser update: next state and the (optional) result for one byte.
module lpfd_step (
   input  lpfd_pkg::cfg_type    cfg,
   input  lpfd_pkg::state_type  cur,
   input  logic [7:0]           data_byte,
   output lpfd_pkg::state_type  nxt,
   output logic                 result_load,
   output lpfd_pkg::result_type result
);

   logic [31:0] acc_ins;
   logic [31:0] stream_ins;
   logic [31:0] rem_dec;
   logic [4:0]  lane;

   always_comb begin
      lane       = {cur.idx, 3'b000};
      acc_ins    = cur.len_acc;
      acc_ins[lane +: 8] = data_byte;
      stream_ins = cur.stream;
      stream_ins[lane +: 8] = data_byte;
      rem_dec    = cur.remaining - 32'd1;

      nxt         = cur;
      result_load = 1'b0;
      result      = '0;

      if (!cur.failed) begin
         case (cur.phase)
            lpfd_pkg::PhLength: begin
               nxt.len_acc = acc_ins;
               if (cur.idx == lpfd_pkg::LastFieldIdx) begin
                  nxt.idx = 2'd0;
                  if (acc_ins < lpfd_pkg::MinFrameLen || acc_ins > cfg.max_frame_length) begin
                     nxt.failed    = 1'b1;
                     result_load   = 1'b1;
                     result.status = lpfd_pkg::StLenErr;
                  end else begin
                     nxt.remaining = acc_ins - lpfd_pkg::MinFrameLen;
                     nxt.phase     = lpfd_pkg::PhType;
                  end
               end else begin
                  nxt.idx = cur.idx + 2'd1;
               end
            end
            lpfd_pkg::PhType: begin
               // equal codes: control wins
               if (data_byte == cfg.control_type_code || data_byte == cfg.binary_type_code) begin
                  nxt.kind   = (data_byte == cfg.control_type_code) ?
                               lpfd_pkg::KindControl : lpfd_pkg::KindBinary;
                  nxt.stream = '0;
                  nxt.idx    = 2'd0;
                  nxt.phase  = lpfd_pkg::PhStream;
               end else begin
                  nxt.failed    = 1'b1;
                  result_load   = 1'b1;
                  result.status = lpfd_pkg::StTypeErr;
               end
            end
            lpfd_pkg::PhStream: begin
               nxt.stream = stream_ins;
               if (cur.idx == lpfd_pkg::LastFieldIdx) begin
                  nxt.idx = 2'd0;
                  if (cur.remaining == 32'd0) begin
                     result_load          = 1'b1;
                     result.status        = lpfd_pkg::StEmpty;
                     result.frame_kind    = cur.kind;
                     result.stream_number = stream_ins;
                     result.last_of_frame = 1'b1;
                     nxt.phase            = lpfd_pkg::PhLength;
                     nxt.len_acc          = '0;
                  end else begin
                     nxt.phase = lpfd_pkg::PhPayload;
                  end
               end else begin
                  nxt.idx = cur.idx + 2'd1;
               end
            end
            default: begin
               nxt.remaining        = rem_dec;
               result_load          = 1'b1;
               result.status        = lpfd_pkg::StPayload;
               result.frame_kind    = cur.kind;
               result.stream_number = cur.stream;
               result.payload_byte  = data_byte;
               result.last_of_frame = (rem_dec == 32'd0);
               if (rem_dec == 32'd0) begin
                  nxt.phase   = lpfd_pkg::PhLength;
                  nxt.idx     = 2'd0;
                  nxt.len_acc = '0;
               end
            end
         endcase
      end
   end

endmodule

// ===== src/length_prefixed_frame_deframer_unit.sv =====
`timescale 1ns / 1ps

// Channel | Dir | Ports                                         | Beat
// req     | in  | req_valid, req_stall(out), req_data_byte      | one stream byte
// rsp     | out | rsp_valid, rsp_stall(in), rsp_status, ...     | one result
// csr     | in  | csr_write_enable, csr_index, csr_write_data   | one register write
//
// One byte per cycle sustained while rsp_stall is low; a req beat passes the input register,
// then the result register, before rsp_valid rises for it.
// Header bytes produce no rsp beat unless they give an error or an empty frame; bytes after an error produce none.
// reset is synchronous, active high; it restores register defaults and clears
// the parser, including the sticky failed state.
// rsp_stall holds the result register; req_stall rises only when a byte is
// parked in the input register and the result register cannot take its output.
module length_prefixed_frame_deframer_unit (
   input  logic        clock,
   input  logic        reset,
   // byte input
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   // results
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic        rsp_frame_kind,
   output logic [31:0] rsp_stream_number,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_last_of_frame,
   // register writes
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data
);

   lpfd_pkg::cfg_type    cfg_ff, cfg_in;
   lpfd_pkg::state_type  state_ff, state_in;
   lpfd_pkg::state_type  step_state;
   lpfd_pkg::result_type step_result;
   lpfd_pkg::result_type out_ff, out_in;
   logic                 step_load;
   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_byte_ff, in_byte_in;
   logic                 out_valid_ff, out_valid_in;
   logic                 advance;
   logic                 step_go;
   logic                 req_take;

   // the result register is free, or its beat leaves this cycle
   assign advance   = !out_valid_ff || !rsp_stall;
   assign step_go   = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   // configuration: writes to an index past the list are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            lpfd_pkg::CsrMaxFrameLength: cfg_in.max_frame_length = csr_write_data;
            lpfd_pkg::CsrControlType:    cfg_in.control_type_code = csr_write_data[7:0];
            lpfd_pkg::CsrBinaryType:     cfg_in.binary_type_code = csr_write_data[7:0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   lpfd_step u_step (
      .cfg         (cfg_ff),
      .cur         (state_ff),
      .data_byte   (in_byte_ff),
      .nxt         (step_state),
      .result_load (step_load),
      .result      (step_result)
   );

   // input register
   always_comb begin
      in_byte_in = req_take ? req_data_byte : in_byte_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (step_go) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // parser state and result register
   always_comb begin
      state_in = step_go ? step_state : state_ff;
      if (step_go) begin
         out_valid_in = step_load;
      end else begin
         out_valid_in = out_valid_ff && rsp_stall;
      end
      out_in = (step_go && step_load) ? step_result : out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_frame_length  <= lpfd_pkg::MaxFrameLengthReset;
         cfg_ff.control_type_code <= lpfd_pkg::ControlTypeReset;
         cfg_ff.binary_type_code  <= lpfd_pkg::BinaryTypeReset;
         state_ff                 <= '0;
         in_valid_ff              <= 1'b0;
         out_valid_ff             <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      out_ff     <= out_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_status        = out_ff.status;
   assign rsp_frame_kind    = out_ff.frame_kind;
   assign rsp_stream_number = out_ff.stream_number;
   assign rsp_payload_byte  = out_ff.payload_byte;
   assign rsp_last_of_frame = out_ff.last_of_frame;

   // an error beat on the output means the parser has latched failed
   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == lpfd_pkg::StLenErr || rsp_status == lpfd_pkg::StTypeErr)
      |-> state_ff.failed)
      else $error("error beat without failed state");

   // once failed, no new result is produced
   a_failed_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff.failed && !rsp_valid |=> !rsp_valid)
      else $error("result after failure");

   // a stall on req only when a byte is parked behind a held result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && rsp_valid && rsp_stall)
      else $error("req_stall without back-pressure");

   // non-payload results carry a zero data byte
   a_zero_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != lpfd_pkg::StPayload |-> rsp_payload_byte == 8'd0)
      else $error("nonzero byte on non-payload result");

endmodule
